[design/ecg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_pkg: shared types and constants of the exposure/contrast/gamma grade
// Fixed-point formats, register indexes, the stage map of a colour lane and
// the exp2 step table.
// ----------------------------------------------------------------------------
package ecg_pkg;

	localparam int FRAC_BITS       = 12;
	localparam int SAMPLE_WIDTH    = 16;
	localparam int COLOUR_CHANNELS = 3;
	localparam int CLIP_W          = 13;
	localparam int GAIN_W          = 18;
	localparam int COEF_W          = 16;
	localparam int LOG_STEPS       = 16;
	localparam int EXP_STEPS       = 16;
	localparam int CFG_IDX_W       = 3;

	// stage map of one colour lane
	localparam int ST_V    = 3;
	localparam int ST_LOG0 = ST_V + 1;
	localparam int ST_E    = ST_LOG0 + LOG_STEPS;
	localparam int ST_EXP0 = ST_E + 1;
	localparam int ST_Y    = ST_EXP0 + EXP_STEPS;
	localparam int NSTAGE  = ST_Y + 1;

	localparam int P_W = $clog2(FRAC_BITS);
	localparam int A_W = P_W + 16;
	localparam int E_W = A_W + COEF_W - FRAC_BITS;
	localparam int N_W = E_W - 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXPOSURE_GAIN = 3'd0,
		REG_LEVEL_OFFSET  = 3'd1,
		REG_CONTRAST_GAIN = 3'd2,
		REG_INVERSE_GAMMA = 3'd3,
		REG_BLACK_CLIP    = 3'd4,
		REG_WHITE_CLIP    = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		VK_POW  = 2'd0,
		VK_LOW  = 2'd1,
		VK_HIGH = 2'd2
	} vkind_t;

	typedef struct packed {
		logic [GAIN_W-1:0]              exposure_gain;
		logic signed [SAMPLE_WIDTH-1:0] level_offset;
		logic [COEF_W-1:0]              contrast_gain;
		logic [COEF_W-1:0]              inverse_gamma;
		logic [CLIP_W-1:0]              black_clip;
		logic [CLIP_W-1:0]              white_clip;
	} cfg_t;

	typedef logic [29:0] exp_tab_t [EXP_STEPS];

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem  = x;
		res  = 64'd0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-(i+1)) in Q.30
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    t;
		logic [63:0] w;
		w = isqrt64(64'd1 << 59);
		t[0] = w[29:0];
		for (int i = 1; i < EXP_STEPS; i++) begin
			w = isqrt64(w << 30);
			t[i] = w[29:0];
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
		input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = (48'sd1 <<< (SAMPLE_WIDTH - 1)) - 48'sd1;
		lo = -(48'sd1 <<< (SAMPLE_WIDTH - 1));
		if (v > hi)
			return hi[SAMPLE_WIDTH-1:0];
		else if (v < lo)
			return lo[SAMPLE_WIDTH-1:0];
		else
			return v[SAMPLE_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

[design/ecg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_if: pixel stream channels
// Valid/ready channels for the RGBA pixel into and the graded pixel out of
// the grade block.
// ----------------------------------------------------------------------------
interface ecg_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [ecg_pkg::SAMPLE_WIDTH-1:0] red_in;
	logic signed [ecg_pkg::SAMPLE_WIDTH-1:0] green_in;
	logic signed [ecg_pkg::SAMPLE_WIDTH-1:0] blue_in;
	logic signed [ecg_pkg::SAMPLE_WIDTH-1:0] alpha_in;
	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface ecg_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [ecg_pkg::CLIP_W-1:0]              red_out;
	logic [ecg_pkg::CLIP_W-1:0]              green_out;
	logic [ecg_pkg::CLIP_W-1:0]              blue_out;
	logic signed [ecg_pkg::SAMPLE_WIDTH-1:0] alpha_out;
	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface
`default_nettype wire

[design/ecg_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_lane: one colour channel of the grade
// Gain, offset and contrast, then x^(1/gamma) by a squaring log2 chain and a
// table-driven exp2 chain, one step per stage, then the clip levels.
// ----------------------------------------------------------------------------
module ecg_lane (
	input  wire logic                                   clk,
	input  wire logic [ecg_pkg::NSTAGE-1:0]             en,
	input  wire ecg_pkg::cfg_t                          cfg,
	input  wire logic signed [ecg_pkg::SAMPLE_WIDTH-1:0] x,
	output logic [ecg_pkg::CLIP_W-1:0]                  y
);
	localparam int F  = ecg_pkg::FRAC_BITS;
	localparam int SW = ecg_pkg::SAMPLE_WIDTH;
	localparam int PW = ecg_pkg::P_W;
	localparam int AW = ecg_pkg::A_W;
	localparam int EW = ecg_pkg::E_W;
	localparam int NW = ecg_pkg::N_W;
	localparam int CW = ecg_pkg::CLIP_W;
	localparam int ST_V    = ecg_pkg::ST_V;
	localparam int ST_LOG0 = ecg_pkg::ST_LOG0;
	localparam int ST_E    = ecg_pkg::ST_E;
	localparam int ST_EXP0 = ecg_pkg::ST_EXP0;
	localparam int ST_Y    = ecg_pkg::ST_Y;
	localparam logic signed [47:0] ONE48  = 48'sd1 <<< F;
	localparam logic signed [47:0] HALF48 = 48'sd1 <<< (F - 1);

	// front stages
	localparam int GAIN_X = ecg_pkg::GAIN_W + 1;
	logic signed [SW+GAIN_X-1:0] prod_s1;
	logic signed [SW-1:0]        v1_s2;
	logic signed [SW+17-1:0]     prod_s3;

	logic signed [SW+GAIN_X-1:0] prod_d;
	logic signed [47:0]          t1;
	logic signed [SW-1:0]        va;
	logic signed [SW-1:0]        vb;
	logic signed [16:0]          dv;
	logic signed [SW+17-1:0]     prod2_d;

	assign prod_d  = x * $signed({1'b0, cfg.exposure_gain});
	assign dv      = 17'(v1_s2) - 17'(HALF48);
	assign prod2_d = (SW+17)'(dv * $signed({1'b0, cfg.contrast_gain}));

	always_comb begin
		t1 = (48'(prod_s1) + HALF48) >>> F;
		va = ecg_pkg::sat_sample(t1);
		vb = ecg_pkg::sat_sample(48'(va) + 48'(cfg.level_offset));
	end

	always_ff @(posedge clk) begin
		if (en[0])
			prod_s1 <= prod_d;
		if (en[1])
			v1_s2 <= vb;
		if (en[2])
			prod_s3 <= prod2_d;
	end

	// classify and normalize
	ecg_pkg::vkind_t kind_s [ST_V:ST_Y-1];
	logic [PW-1:0]   p_s    [ST_V:ST_E-1];
	logic [16:0]     m_s    [ST_V:ST_E-1];
	logic [15:0]     fr_s   [ST_V:ST_E-1];

	logic signed [47:0]   t3;
	logic signed [SW-1:0] vc;
	ecg_pkg::vkind_t      kind_d;
	logic [F-1:0]         vf;
	logic [PW-1:0]        p_d;

	always_comb begin
		t3 = ((48'(prod_s3) + HALF48) >>> F) + HALF48;
		vc = ecg_pkg::sat_sample(t3);
		if (48'(vc) >= ONE48)
			kind_d = ecg_pkg::VK_HIGH;
		else if (vc <= 0)
			kind_d = ecg_pkg::VK_LOW;
		else
			kind_d = ecg_pkg::VK_POW;
		vf  = vc[F-1:0];
		p_d = '0;
		for (int i = 0; i < F; i++)
			if (vf[i])
				p_d = PW'(i);
	end

	always_ff @(posedge clk) begin
		if (en[ST_V]) begin
			kind_s[ST_V] <= kind_d;
			p_s[ST_V]    <= p_d;
			m_s[ST_V]    <= 17'(17'(vf) << (5'd16 - 5'(p_d)));
			fr_s[ST_V]   <= '0;
		end
	end

	// log2 fraction: one squaring per stage
	for (genvar j = 0; j < ecg_pkg::LOG_STEPS; j++) begin : g_log
		localparam int K = ST_LOG0 + j;
		logic [33:0] sq;
		logic [17:0] t;
		assign sq = 34'(m_s[K-1]) * 34'(m_s[K-1]);
		assign t  = sq[33:16];
		always_ff @(posedge clk) begin
			if (en[K]) begin
				kind_s[K] <= kind_s[K-1];
				p_s[K]    <= p_s[K-1];
				m_s[K]    <= t[17] ? t[17:1] : t[16:0];
				fr_s[K]   <= {fr_s[K-1][14:0], t[17]};
			end
		end
	end

	// scale -log2(v) by 1/gamma
	logic [NW-1:0] n_s [ST_E:ST_Y-1];
	logic [15:0]   f_s [ST_E:ST_Y-1];
	logic [30:0]   r_s [ST_E:ST_Y-1];

	logic [AW-1:0]      a_d;
	logic [AW+15:0]     ap_d;
	logic [EW-1:0]      e_d;

	always_comb begin
		a_d  = {(PW'(F) - p_s[ST_E-1]), 16'd0} - AW'(fr_s[ST_E-1]);
		ap_d = (AW+16)'(a_d) * (AW+16)'(cfg.inverse_gamma) + (AW+16)'(1 << (F - 1));
		e_d  = EW'(ap_d >> F);
	end

	always_ff @(posedge clk) begin
		if (en[ST_E]) begin
			kind_s[ST_E] <= kind_s[ST_E-1];
			n_s[ST_E]    <= e_d[EW-1:16];
			f_s[ST_E]    <= e_d[15:0];
			r_s[ST_E]    <= 31'd1 << 30;
		end
	end

	// exp2 of the fraction: one table factor per stage
	for (genvar j = 0; j < ecg_pkg::EXP_STEPS; j++) begin : g_exp
		localparam int K = ST_EXP0 + j;
		logic [60:0] pr;
		logic [60:0] rr;
		assign pr = 61'(r_s[K-1]) * 61'(ecg_pkg::EXP_TAB[j]);
		assign rr = (pr + (61'd1 << 29)) >> 30;
		always_ff @(posedge clk) begin
			if (en[K]) begin
				kind_s[K] <= kind_s[K-1];
				n_s[K]    <= n_s[K-1];
				f_s[K]    <= f_s[K-1];
				r_s[K]    <= f_s[K-1][15-j] ? rr[30:0] : r_s[K-1];
			end
		end
	end

	// final shift and clip
	logic [CW-1:0]  y_s;
	logic [NW:0]    sh;
	logic [41:0]    yr;
	logic [CW-1:0]  yp;
	logic [CW-1:0]  yd;
	logic [CW-1:0]  cb;
	logic [CW-1:0]  cw;

	always_comb begin
		cb = cfg.black_clip;
		cw = cfg.white_clip;
		sh = (NW+1)'(30 - F) + (NW+1)'(n_s[ST_Y-1]);
		if (sh > (NW+1)'(40))
			yr = '0;
		else
			yr = (42'(r_s[ST_Y-1]) + (42'd1 << (sh - 1'b1))) >> sh;
		yp = (yr > 42'(cw)) ? cw : yr[CW-1:0];
		case (kind_s[ST_Y-1])
			ecg_pkg::VK_HIGH: yd = (cw > cb) ? cw : cb;
			ecg_pkg::VK_LOW:  yd = cb;
			ecg_pkg::VK_POW:  yd = (yp < cb) ? cb : yp;
			default:          yd = cb;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[ST_Y])
			y_s <= yd;
	end

	assign y = y_s;

endmodule
`default_nettype wire

[design/ecg_flow.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_flow: pipeline flow control and alpha line
// Per-stage valid bits with bubble collapsing, stage enables for the lanes,
// and the alpha delay line that keeps alpha with its pixel.
// ----------------------------------------------------------------------------
module ecg_flow (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [ecg_pkg::SAMPLE_WIDTH-1:0] alpha_in,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [ecg_pkg::SAMPLE_WIDTH-1:0]      alpha_out,
	output logic [ecg_pkg::NSTAGE-1:0]                  en
);
	localparam int NS = ecg_pkg::NSTAGE;

	logic [NS-1:0]                      vld_q;
	logic signed [ecg_pkg::SAMPLE_WIDTH-1:0] alpha_s [NS];

	// a stage may load when it is empty or its contents move on
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0])
			alpha_s[0] <= alpha_in;
		for (int k = 1; k < NS; k++)
			if (en[k])
				alpha_s[k] <= alpha_s[k-1];
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NS-1];
	assign alpha_out = alpha_s[NS-1];

endmodule
`default_nettype wire

[design/exposure_contrast_gamma_grade.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exposure_contrast_gamma_grade: RGBA exposure, contrast and gamma grade
// Colour lanes side by side, one per channel, merged with alpha into one
// output transaction.
//
//   channel   dir  handshake      payload
//   pix_in    in   valid/ready    red_in, green_in, blue_in, alpha_in
//   pix_out   out  valid/ready    red_out, green_out, blue_out, alpha_out
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// One pixel per clock while the output is not stalled. Stages: four front,
// sixteen log2 squaring, one scaling, sixteen exp2 and the output register.
// Each stage holds while the one after it is full and stalled, so bubbles
// collapse and the input takes pixels while a finished one waits, until no
// stage is empty. Reset clears the valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module exposure_contrast_gamma_grade (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ecg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ecg_pkg::GAIN_W-1:0]         cfg_data,
	ecg_in_if.sink                                  pix_in,
	ecg_out_if.source                               pix_out
);
	ecg_pkg::cfg_t                cfg_q;
	logic [ecg_pkg::NSTAGE-1:0]   en;
	logic [ecg_pkg::CLIP_W-1:0]   col [3];
	logic signed [ecg_pkg::SAMPLE_WIDTH-1:0] xin [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exposure_gain <= ecg_pkg::GAIN_W'(1 << ecg_pkg::FRAC_BITS);
			cfg_q.level_offset  <= '0;
			cfg_q.contrast_gain <= ecg_pkg::COEF_W'(1 << ecg_pkg::FRAC_BITS);
			cfg_q.inverse_gamma <= ecg_pkg::COEF_W'(1 << ecg_pkg::FRAC_BITS);
			cfg_q.black_clip    <= '0;
			cfg_q.white_clip    <= ecg_pkg::CLIP_W'(1 << ecg_pkg::FRAC_BITS);
		end else if (cfg_we) begin
			case (cfg_index)
				ecg_pkg::REG_EXPOSURE_GAIN: cfg_q.exposure_gain <= cfg_data;
				ecg_pkg::REG_LEVEL_OFFSET:  cfg_q.level_offset  <= cfg_data[15:0];
				ecg_pkg::REG_CONTRAST_GAIN: cfg_q.contrast_gain <= cfg_data[15:0];
				ecg_pkg::REG_INVERSE_GAMMA: cfg_q.inverse_gamma <= cfg_data[15:0];
				ecg_pkg::REG_BLACK_CLIP:    cfg_q.black_clip    <= cfg_data[12:0];
				ecg_pkg::REG_WHITE_CLIP:    cfg_q.white_clip    <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	ecg_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.alpha_in  (pix_in.alpha_in),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.alpha_out (pix_out.alpha_out),
		.en        (en)
	);

	assign xin[0] = pix_in.red_in;
	assign xin[1] = pix_in.green_in;
	assign xin[2] = pix_in.blue_in;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		if (c < ecg_pkg::COLOUR_CHANNELS) begin : g_on
			ecg_lane u_lane (
				.clk (clk),
				.en  (en),
				.cfg (cfg_q),
				.x   (xin[c]),
				.y   (col[c])
			);
		end else begin : g_off
			assign col[c] = '0;
		end
	end

	assign pix_out.red_out   = col[0];
	assign pix_out.green_out = col[1];
	assign pix_out.blue_out  = col[2];

endmodule
`default_nettype wire
